// ===== sv/hcmtp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the height/color map token parser.
// No dependencies; used by hcmtp_step, the top level and the checker.

package hcmtp_pkg;

  localparam int ALT_BITS_DEF   = 32;
  localparam int INDEX_BITS_DEF = 16;

  localparam int CH_W    = 8;
  localparam int COLOR_W = 24;
  localparam int ALT_W   = 32;
  localparam int IDX_W   = 16;
  localparam int KIND_W  = 2;
  localparam int TDATA_W = ALT_W + COLOR_W + 2 * IDX_W;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_GAP     = 3'd1,
    PH_SIGN    = 3'd2,
    PH_DIGITS  = 3'd3,
    PH_SKIP    = 3'd4,
    PH_HEX     = 3'd5,
    PH_ERR_ALT = 3'd6,
    PH_ERR_COL = 3'd7
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_POINT   = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ALT_ERR = 2'd2,
    KIND_COL_ERR = 2'd3
  } kind_t;

  typedef struct packed {
    phase_t             phase;
    logic               negative;
    logic [1:0]         skip_count;
    logic [COLOR_W-1:0] color_acc;
  } ctrl_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [ALT_W-1:0]   altitude;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   column;
    logic [IDX_W-1:0]   row_index;
    logic               last;
  } result_t;

endpackage

// ===== sv/hcmtp_step.sv =====
`timescale 1ns / 1ps
// One parse step: next parser state and the optional result for one text byte.
// Depends on hcmtp_pkg.

module hcmtp_step #(
  parameter int ALT_BITS   = hcmtp_pkg::ALT_BITS_DEF,
  parameter int INDEX_BITS = hcmtp_pkg::INDEX_BITS_DEF
) (
  input  logic [hcmtp_pkg::CH_W-1:0]    ch,
  input  hcmtp_pkg::ctrl_t              ctrl,
  input  logic [ALT_BITS-1:0]           value_acc,
  input  logic [INDEX_BITS-1:0]         column_count,
  input  logic [INDEX_BITS-1:0]         row_count,
  input  logic [hcmtp_pkg::COLOR_W-1:0] default_color,
  output hcmtp_pkg::ctrl_t              ctrl_next,
  output logic [ALT_BITS-1:0]           value_next,
  output logic [INDEX_BITS-1:0]         column_next,
  output logic [INDEX_BITS-1:0]         row_next,
  output hcmtp_pkg::result_t            result
);

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  logic                          is_digit;
  logic [3:0]                    d;
  logic [4:0]                    hex;
  logic [ALT_BITS+3:0]           prod;
  logic [ALT_BITS+3:0]           limit;
  logic [ALT_BITS-1:0]           alt_word;
  logic [1:0]                    skip_dec;

  logic                          emit;
  hcmtp_pkg::kind_t              ekind;
  logic                          elast;
  logic [hcmtp_pkg::COLOR_W-1:0] ecolor;
  hcmtp_pkg::ctrl_t              ctrl_upd;
  logic [ALT_BITS-1:0]           val_upd;

  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign d        = ch[3:0];
  assign hex      = hex_decode(ch);
  assign skip_dec = ctrl.skip_count - 2'd1;

  // value * 10 + digit, checked against the signed range
  assign prod  = ({4'b0, value_acc} << 3) + ({4'b0, value_acc} << 1)
               + {{ALT_BITS{1'b0}}, d};
  assign limit = ({{(ALT_BITS+3){1'b0}}, 1'b1} << (ALT_BITS - 1))
               - {{(ALT_BITS+3){1'b0}}, ~ctrl.negative};

  assign alt_word = ctrl.negative ? (~value_acc + {{(ALT_BITS-1){1'b0}}, 1'b1}) : value_acc;

  always_comb begin : decide
    emit     = 1'b0;
    ekind    = hcmtp_pkg::KIND_POINT;
    elast    = 1'b0;
    ecolor   = '0;
    ctrl_upd = ctrl;
    val_upd  = value_acc;
    unique case (ctrl.phase)
      hcmtp_pkg::PH_START, hcmtp_pkg::PH_GAP: begin
        priority if (ch == hcmtp_pkg::CH_NUL) begin
          emit  = 1'b1;
          ekind = hcmtp_pkg::KIND_EMPTY;
          elast = 1'b1;
        end else if (ch == hcmtp_pkg::CH_SPACE ||
                     (ch == hcmtp_pkg::CH_NL && ctrl.phase == hcmtp_pkg::PH_GAP)) begin
          // skip
        end else if (ch == hcmtp_pkg::CH_MINUS) begin
          ctrl_upd.negative = 1'b1;
          ctrl_upd.phase    = hcmtp_pkg::PH_SIGN;
        end else if (is_digit) begin
          val_upd        = {{(ALT_BITS-4){1'b0}}, d};
          ctrl_upd.phase = hcmtp_pkg::PH_DIGITS;
        end else begin
          ctrl_upd.phase = hcmtp_pkg::PH_ERR_ALT;
        end
      end
      hcmtp_pkg::PH_SIGN: begin
        priority if (ch == hcmtp_pkg::CH_NUL) begin
          emit  = 1'b1;
          ekind = hcmtp_pkg::KIND_ALT_ERR;
          elast = 1'b1;
        end else if (ch == hcmtp_pkg::CH_SPACE) begin
          // skip
        end else if (ch == hcmtp_pkg::CH_MINUS) begin
          ctrl_upd.negative = ~ctrl.negative;
        end else if (is_digit) begin
          val_upd        = {{(ALT_BITS-4){1'b0}}, d};
          ctrl_upd.phase = hcmtp_pkg::PH_DIGITS;
        end else begin
          ctrl_upd.phase = hcmtp_pkg::PH_ERR_ALT;
        end
      end
      hcmtp_pkg::PH_DIGITS: begin
        priority if (is_digit) begin
          if (prod > limit) ctrl_upd.phase = hcmtp_pkg::PH_ERR_ALT;
          else              val_upd        = prod[ALT_BITS-1:0];
        end else if (ch == hcmtp_pkg::CH_COMMA) begin
          ctrl_upd.skip_count = 2'd2;
          ctrl_upd.phase      = hcmtp_pkg::PH_SKIP;
        end else if (ch == hcmtp_pkg::CH_SPACE || ch == hcmtp_pkg::CH_NL ||
                     ch == hcmtp_pkg::CH_NUL) begin
          emit   = 1'b1;
          elast  = (ch == hcmtp_pkg::CH_NUL);
          ecolor = default_color;
        end else begin
          ctrl_upd.phase = hcmtp_pkg::PH_ERR_ALT;
        end
      end
      hcmtp_pkg::PH_SKIP: begin
        if (ch == hcmtp_pkg::CH_NUL) begin
          emit  = 1'b1;
          ekind = hcmtp_pkg::KIND_COL_ERR;
          elast = 1'b1;
        end else begin
          ctrl_upd.skip_count = skip_dec;
          if (skip_dec == 2'd0) begin
            ctrl_upd.color_acc = '0;
            ctrl_upd.phase     = hcmtp_pkg::PH_HEX;
          end
        end
      end
      hcmtp_pkg::PH_HEX: begin
        priority if (hex[4]) begin
          if (ctrl.color_acc[23:20] != 4'd0) ctrl_upd.phase = hcmtp_pkg::PH_ERR_COL;
          else ctrl_upd.color_acc = {ctrl.color_acc[19:0], hex[3:0]};
        end else if (ch == hcmtp_pkg::CH_SPACE || ch == hcmtp_pkg::CH_NL ||
                     ch == hcmtp_pkg::CH_NUL) begin
          emit   = 1'b1;
          elast  = (ch == hcmtp_pkg::CH_NUL);
          ecolor = ctrl.color_acc;
        end else begin
          ctrl_upd.phase = hcmtp_pkg::PH_ERR_COL;
        end
      end
      hcmtp_pkg::PH_ERR_ALT: begin
        if (ch == hcmtp_pkg::CH_NUL) begin
          emit  = 1'b1;
          ekind = hcmtp_pkg::KIND_ALT_ERR;
          elast = 1'b1;
        end
      end
      hcmtp_pkg::PH_ERR_COL: begin
        if (ch == hcmtp_pkg::CH_NUL) begin
          emit  = 1'b1;
          ekind = hcmtp_pkg::KIND_COL_ERR;
          elast = 1'b1;
        end
      end
      default: begin
        ctrl_upd = ctrl;
      end
    endcase
  end

  always_comb begin : next_state
    ctrl_next   = ctrl_upd;
    value_next  = val_upd;
    column_next = column_count;
    row_next    = row_count;
    if (emit) begin
      ctrl_next.negative   = 1'b0;
      ctrl_next.skip_count = '0;
      ctrl_next.color_acc  = '0;
      value_next           = '0;
      if (elast) begin
        row_next        = row_count + INDEX_BITS'(1);
        column_next     = '0;
        ctrl_next.phase = hcmtp_pkg::PH_START;
      end else begin
        column_next     = column_count + INDEX_BITS'(1);
        ctrl_next.phase = hcmtp_pkg::PH_GAP;
      end
    end
  end

  always_comb begin : outputs
    result.valid     = emit;
    result.kind      = ekind;
    result.altitude  = (ekind == hcmtp_pkg::KIND_POINT) ?
                       hcmtp_pkg::ALT_W'($signed(alt_word)) : '0;
    result.color     = ecolor;
    result.column    = hcmtp_pkg::IDX_W'(column_count);
    result.row_index = hcmtp_pkg::IDX_W'(row_count);
    result.last      = elast;
  end

endmodule

// ===== sv/height_color_map_token_parser_top.sv =====
`timescale 1ns / 1ps
// Height/color map token parser, top level: stream ports, state and output register.
// Depends on hcmtp_pkg and hcmtp_step.

// Takes one text byte per cycle and gives each point (or row-end / error word) in the
// cycle after the byte that finishes it. The per-byte step (decode, multiply-by-ten
// accumulate with range check) is combinational, so a byte is taken every cycle as
// long as the single output register is empty or being drained; s_axis_tready drops
// only while a word waits there with m_axis_tready low. default_color may be written
// at any time the block is idle; cfg_ready is always high.

module height_color_map_token_parser_top #(
  parameter int ALT_BITS   = hcmtp_pkg::ALT_BITS_DEF,
  parameter int INDEX_BITS = hcmtp_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hcmtp_pkg::COLOR_W-1:0] cfg_data,       // default_color
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hcmtp_pkg::CH_W-1:0]    s_axis_tdata,   // ch
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // altitude[31:0], color[55:32], column[71:56], row_index[87:72]
  output logic [hcmtp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [hcmtp_pkg::KIND_W-1:0]  m_axis_tuser,   // kind
  output logic                          m_axis_tlast    // last_in_row
);

  logic [hcmtp_pkg::COLOR_W-1:0] default_color;
  hcmtp_pkg::ctrl_t              ctrl;
  hcmtp_pkg::ctrl_t              ctrl_next;
  logic [ALT_BITS-1:0]           value_acc;
  logic [ALT_BITS-1:0]           value_acc_next;
  logic [INDEX_BITS-1:0]         column_count;
  logic [INDEX_BITS-1:0]         column_count_next;
  logic [INDEX_BITS-1:0]         row_count;
  logic [INDEX_BITS-1:0]         row_count_next;
  hcmtp_pkg::result_t            result;
  logic                          in_fire;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  hcmtp_step #(
    .ALT_BITS   (ALT_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_step (
    .ch            (s_axis_tdata),
    .ctrl          (ctrl),
    .value_acc     (value_acc),
    .column_count  (column_count),
    .row_count     (row_count),
    .default_color (default_color),
    .ctrl_next     (ctrl_next),
    .value_next    (value_acc_next),
    .column_next   (column_count_next),
    .row_next      (row_count_next),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= hcmtp_pkg::COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      default_color <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase      <= hcmtp_pkg::PH_START;
      ctrl.negative   <= 1'b0;
      ctrl.skip_count <= '0;
      ctrl.color_acc  <= '0;
      value_acc       <= '0;
      column_count    <= '0;
      row_count       <= '0;
    end else if (in_fire) begin
      ctrl         <= ctrl_next;
      value_acc    <= value_acc_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= result.valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && result.valid) begin
      m_axis_tdata <= {result.row_index, result.column, result.color, result.altitude};
      m_axis_tuser <= result.kind;
      m_axis_tlast <= result.last;
    end
  end

endmodule

// ===== sv/hcmtp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the height/color map token parser, bound to the top level.
// Depends on hcmtp_pkg and height_color_map_token_parser_top.

module hcmtp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [hcmtp_pkg::CH_W-1:0]    s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hcmtp_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [hcmtp_pkg::KIND_W-1:0]  m_axis_tuser,
  input logic                          m_axis_tlast
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // non-point words close the row and carry no altitude or color
  a_nonpoint: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != hcmtp_pkg::KIND_POINT |->
      m_axis_tlast && m_axis_tdata[55:0] == '0)
    else $error("bad non-point word");

  // input only stalls behind a waiting output word
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // every accepted row-end byte closes the row on the next cycle
  a_rowend: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tdata == hcmtp_pkg::CH_NUL |=>
      m_axis_tvalid && m_axis_tlast)
    else $error("row end byte gave no closing word");

endmodule

bind height_color_map_token_parser_top hcmtp_checker u_hcmtp_checker (.*);
